// ===== sv/lzt_pkg.sv =====
// ----------------------------------------------------------------------------
// lzt_pkg
// Shared types and constants for the layer z-order table with hit test.
// ----------------------------------------------------------------------------
package lzt_pkg;

    // Fixed field widths of the stream items
    localparam int ID_W        = 6;
    localparam int IN_COORD_W  = 16;
    localparam int SIZE_W      = 16;
    localparam int TH_W        = 8;
    localparam int SH_W        = 7;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 16;

    // Operation codes
    typedef enum logic [2:0] {
        FUNC_NEW        = 3'd0,
        FUNC_SIZE       = 3'd1,
        FUNC_MOVE_ABS   = 3'd2,
        FUNC_MOVE_REL   = 3'd3,
        FUNC_SET_HEIGHT = 3'd4,
        FUNC_HIT        = 3'd5,
        FUNC_GET_HEIGHT = 3'd6
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Kinds of walk over the stack
    typedef enum logic [1:0] {
        SCAN_FIND   = 2'd0,
        SCAN_REMOVE = 2'd1,
        SCAN_INSERT = 2'd2,
        SCAN_HIT    = 2'd3
    } scan_mode_t;

    // Input item; the last declared field, func, sits in the lowest bits
    typedef struct packed {
        logic [ID_W-1:0]              skip_id;
        logic signed [TH_W-1:0]       target_height;
        logic [SIZE_W-1:0]            size_h;
        logic [SIZE_W-1:0]            size_w;
        logic signed [IN_COORD_W-1:0] coord_y;
        logic signed [IN_COORD_W-1:0] coord_x;
        logic [ID_W-1:0]              tgt_id;
        func_t                        func;
    } lzt_item_t;

    // Result item; the last declared field, status, sits in the lowest bits
    typedef struct packed {
        logic signed [SH_W-1:0] stack_height;
        logic [ID_W-1:0]        result_id;
        status_t                status;
    } lzt_result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       attr_new;
        logic       attr_upd;
        logic       id_inc;
        logic       rid_new;
        logic       set_status;
        status_t    status_val;
        logic       height_neg;
        logic       height_find;
        logic       scan_start;
        logic       scan_run;
        scan_mode_t mode;
        logic       h_load;
        logic       len_dec;
        logic       ins_put;
        logic       out_load;
    } lzt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        func_t func;
        logic  known;
        logic  full;
        logic  th_neg;
        logic  found;
        logic  scan_end;
        logic  out_free;
    } lzt_stat_t;

endpackage

// ===== sv/lzt_ram.sv =====
// ----------------------------------------------------------------------------
// lzt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lzt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/lzt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzt_ctrl
// Operation sequencer: decodes each beat and steps the datapath through it.
// ----------------------------------------------------------------------------
module lzt_ctrl
    import lzt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lzt_stat_t stat,
    output lzt_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_ATTR_WR  = 8'b0000_0100,
        S_FIND     = 8'b0000_1000,
        S_REMOVE   = 8'b0001_0000,
        S_INSERT   = 8'b0010_0000,
        S_HIT      = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.func)
                    FUNC_NEW:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_FULL;
                        end
                        else
                        begin
                            cmd.attr_new = 1'b1;
                            cmd.id_inc   = 1'b1;
                            cmd.rid_new  = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    FUNC_SIZE, FUNC_MOVE_ABS, FUNC_MOVE_REL:
                    begin
                        if (!stat.known)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_UNKNOWN;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ATTR_WR;
                        end
                    end
                    FUNC_SET_HEIGHT, FUNC_GET_HEIGHT:
                    begin
                        if (!stat.known)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_UNKNOWN;
                            cmd.height_neg = (stat.func == FUNC_GET_HEIGHT);
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.mode       = SCAN_FIND;
                            state_next     = S_FIND;
                        end
                    end
                    FUNC_HIT:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.mode       = SCAN_HIT;
                        state_next     = S_HIT;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ATTR_WR:
            begin
                cmd.attr_upd = 1'b1;
                state_next   = S_DONE;
            end
            S_FIND:
            begin
                if (!stat.scan_end)
                begin
                    cmd.scan_run = 1'b1;
                end
                else if (stat.func == FUNC_GET_HEIGHT)
                begin
                    cmd.height_find = 1'b1;
                    state_next      = S_DONE;
                end
                else if (stat.th_neg)
                begin
                    if (stat.found)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.mode       = SCAN_REMOVE;
                        state_next     = S_REMOVE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.h_load     = 1'b1;
                    cmd.scan_start = 1'b1;
                    if (stat.found)
                    begin
                        cmd.mode   = SCAN_REMOVE;
                        state_next = S_REMOVE;
                    end
                    else
                    begin
                        cmd.mode   = SCAN_INSERT;
                        state_next = S_INSERT;
                    end
                end
            end
            S_REMOVE:
            begin
                if (!stat.scan_end)
                begin
                    cmd.scan_run = 1'b1;
                end
                else
                begin
                    cmd.len_dec = 1'b1;
                    if (stat.th_neg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.mode       = SCAN_INSERT;
                        state_next     = S_INSERT;
                    end
                end
            end
            S_INSERT:
            begin
                if (!stat.scan_end)
                begin
                    cmd.scan_run = 1'b1;
                end
                else
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_HIT:
            begin
                if (!stat.scan_end)
                begin
                    cmd.scan_run = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/lzt_dp.sv =====
// ----------------------------------------------------------------------------
// lzt_dp
// Datapath: layer attribute RAM, stack RAM, stack walker, hit comparator and
// the result and output registers.
// ----------------------------------------------------------------------------
module lzt_dp
    import lzt_pkg::*;
#(
    parameter int MAX_LAYERS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  lzt_item_t   item,
    input  lzt_cmd_t    cmd,
    output lzt_stat_t   stat,
    input  logic        out_ready,
    output logic        out_valid,
    output lzt_result_t out_data
);

    localparam int IDX_W   = $clog2(MAX_LAYERS);
    localparam int CNT_W   = $clog2(MAX_LAYERS + 1);
    localparam int Y_LO    = COORD_BITS;
    localparam int W_LO    = 2 * COORD_BITS;
    localparam int H_LO    = W_LO + SIZE_W;
    localparam int WIN_BIT = H_LO + SIZE_W;
    localparam int ATTR_W  = WIN_BIT + 1;
    localparam int CMP_W   = ((COORD_BITS > IN_COORD_W) ? COORD_BITS : IN_COORD_W) + 2;

    lzt_item_t         item_reg;
    logic [CNT_W-1:0]  next_id_reg, next_id_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  h_reg;
    scan_mode_t        mode_reg;
    logic              p1_vld_reg, p1_vld_next;
    logic [IDX_W-1:0]  p1_idx_reg;
    logic              p2_vld_reg, p2_vld_next;
    logic [ID_W-1:0]   p2_lid_reg;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  old_reg;
    lzt_result_t       res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    lzt_result_t       out_reg;

    logic [ID_W-1:0]   id_m1;
    logic [IDX_W-1:0]  k_idx;
    logic              scan_up;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  ptr_m1;
    logic              issue;
    logic [IDX_W-1:0]  issue_idx;
    logic              scan_idle;
    logic              find_hit;

    logic              stk_we;
    logic [IDX_W-1:0]  stk_waddr;
    logic [ID_W-1:0]   stk_wdata;
    logic [ID_W-1:0]   stk_rdata;

    logic [ID_W-1:0]   lid_m1;
    logic              lid_ok;
    logic              attr_we;
    logic [IDX_W-1:0]  attr_waddr;
    logic [IDX_W-1:0]  attr_raddr;
    logic [ATTR_W-1:0] attr_wdata;
    logic [ATTR_W-1:0] attr_rdata;
    logic [ATTR_W-1:0] upd_word;

    logic [COORD_BITS-1:0] rd_x, rd_y;
    logic signed [CMP_W-1:0] x0, y0, x1, y1, px, py;
    logic              holds;

    logic [TH_W-1:0]   th_u;
    logic [CNT_W-1:0]  h_clamp, h_fix;

    // Item decode
    assign id_m1 = item_reg.tgt_id - ID_W'(1);
    assign k_idx = id_m1[IDX_W-1:0];
    assign stat.func   = item_reg.func;
    assign stat.known  = (item_reg.tgt_id != '0) &&
                         (item_reg.tgt_id <= ID_W'(next_id_reg));
    assign stat.full   = (next_id_reg == CNT_W'(MAX_LAYERS));
    assign stat.th_neg = item_reg.target_height[TH_W-1];
    assign stat.found  = found_reg;

    // Stack walker: upward for find and remove, downward for insert and hit
    assign scan_up   = (mode_reg == SCAN_FIND) || (mode_reg == SCAN_REMOVE);
    assign lim       = (mode_reg == SCAN_INSERT) ? h_reg : '0;
    assign ptr_m1    = ptr_reg - CNT_W'(1);
    assign issue     = scan_up ? (ptr_reg < len_reg) : (ptr_reg > lim);
    assign issue_idx = scan_up ? ptr_reg[IDX_W-1:0] : ptr_m1[IDX_W-1:0];
    assign scan_idle = !issue && !p1_vld_reg && !p2_vld_reg;
    assign stat.scan_end = scan_idle ||
        (((mode_reg == SCAN_FIND) || (mode_reg == SCAN_HIT)) && found_reg);
    assign find_hit  = cmd.scan_run && (mode_reg == SCAN_FIND) && p1_vld_reg &&
                       (stk_rdata == item_reg.tgt_id);

    // Stack writes: shift one slot per beat of the walk, or place the layer
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = p1_idx_reg;
        stk_wdata = stk_rdata;
        if (cmd.ins_put)
        begin
            stk_we    = 1'b1;
            stk_waddr = h_reg[IDX_W-1:0];
            stk_wdata = item_reg.tgt_id;
        end
        else if (cmd.scan_run && p1_vld_reg && (mode_reg == SCAN_REMOVE))
        begin
            stk_we    = 1'b1;
            stk_waddr = p1_idx_reg - IDX_W'(1);
        end
        else if (cmd.scan_run && p1_vld_reg && (mode_reg == SCAN_INSERT))
        begin
            stk_we    = 1'b1;
            stk_waddr = p1_idx_reg + IDX_W'(1);
        end
    end

    lzt_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_LAYERS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (issue_idx),
        .rdata (stk_rdata)
    );

    // Attribute reads: the target layer, or the stack entry during a hit test
    assign lid_m1     = stk_rdata - ID_W'(1);
    assign lid_ok     = (stk_rdata != item_reg.skip_id) && (stk_rdata != '0) &&
                        (stk_rdata <= ID_W'(MAX_LAYERS));
    assign attr_raddr = (item_reg.func == FUNC_HIT) ? lid_m1[IDX_W-1:0] : k_idx;

    assign rd_x = attr_rdata[COORD_BITS-1:0];
    assign rd_y = attr_rdata[Y_LO +: COORD_BITS];

    // Read-modify-write of one layer's attributes
    always_comb
    begin
        upd_word = attr_rdata;
        case (item_reg.func)
            FUNC_SIZE:
            begin
                upd_word[WIN_BIT]           = 1'b1;
                upd_word[H_LO +: SIZE_W]    = item_reg.size_h;
                upd_word[W_LO +: SIZE_W]    = item_reg.size_w;
            end
            FUNC_MOVE_ABS:
            begin
                upd_word[Y_LO +: COORD_BITS] = COORD_BITS'(item_reg.coord_y);
                upd_word[COORD_BITS-1:0]     = COORD_BITS'(item_reg.coord_x);
            end
            FUNC_MOVE_REL:
            begin
                upd_word[Y_LO +: COORD_BITS] = rd_y + COORD_BITS'(item_reg.coord_y);
                upd_word[COORD_BITS-1:0]     = rd_x + COORD_BITS'(item_reg.coord_x);
            end
            default:
            begin
                upd_word = attr_rdata;
            end
        endcase
    end

    assign attr_we    = cmd.attr_new || cmd.attr_upd;
    assign attr_waddr = cmd.attr_new ? next_id_reg[IDX_W-1:0] : k_idx;
    assign attr_wdata = cmd.attr_new ? '0 : upd_word;

    lzt_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (MAX_LAYERS)
    ) u_attr_ram (
        .clk   (clk),
        .we    (attr_we),
        .waddr (attr_waddr),
        .wdata (attr_wdata),
        .raddr (attr_raddr),
        .rdata (attr_rdata)
    );

    // Window containment test, widened so that no sum overflows
    assign x0 = CMP_W'($signed(rd_x));
    assign y0 = CMP_W'($signed(rd_y));
    assign x1 = x0 + CMP_W'(attr_rdata[W_LO +: SIZE_W]);
    assign y1 = y0 + CMP_W'(attr_rdata[H_LO +: SIZE_W]);
    assign px = CMP_W'(item_reg.coord_x);
    assign py = CMP_W'(item_reg.coord_y);
    assign holds = attr_rdata[WIN_BIT] && (x0 <= px) && (px < x1) &&
                   (y0 <= py) && (py < y1);

    // Target height, clamped to the stack
    assign th_u    = item_reg.target_height;
    assign h_clamp = (th_u > TH_W'(len_reg)) ? len_reg : CNT_W'(th_u);
    assign h_fix   = (found_reg && (h_clamp == len_reg) && (h_clamp != '0)) ?
                     (h_clamp - CNT_W'(1)) : h_clamp;

    // Counters and walker next state
    always_comb
    begin
        next_id_next = cmd.id_inc ? (next_id_reg + CNT_W'(1)) : next_id_reg;

        len_next = len_reg;
        if (cmd.len_dec)
        begin
            len_next = len_reg - CNT_W'(1);
        end
        else if (cmd.ins_put)
        begin
            len_next = len_reg + CNT_W'(1);
        end

        ptr_next    = ptr_reg;
        p1_vld_next = 1'b0;
        p2_vld_next = 1'b0;
        if (cmd.scan_start)
        begin
            case (cmd.mode)
                SCAN_FIND:   ptr_next = '0;
                SCAN_REMOVE: ptr_next = CNT_W'(old_reg) + CNT_W'(1);
                SCAN_INSERT: ptr_next = len_next;
                SCAN_HIT:    ptr_next = len_reg;
                default:     ptr_next = '0;
            endcase
        end
        else if (cmd.scan_run)
        begin
            p1_vld_next = issue;
            p2_vld_next = p1_vld_reg && (mode_reg == SCAN_HIT) && lid_ok;
            if (issue)
            begin
                ptr_next = scan_up ? (ptr_reg + CNT_W'(1)) : ptr_m1;
            end
        end

        found_next = found_reg;
        if (cmd.scan_start && ((cmd.mode == SCAN_FIND) || (cmd.mode == SCAN_HIT)))
        begin
            found_next = 1'b0;
        end
        else if (find_hit)
        begin
            found_next = 1'b1;
        end
        else if (cmd.scan_run && (mode_reg == SCAN_HIT) && p2_vld_reg && holds)
        begin
            found_next = 1'b1;
        end
    end

    // Result fields
    always_comb
    begin
        res_next = res_reg;
        if (cmd.capture)
        begin
            res_next = '0;
        end
        if (cmd.set_status)
        begin
            res_next.status = cmd.status_val;
        end
        if (cmd.rid_new)
        begin
            res_next.result_id = ID_W'(next_id_reg + CNT_W'(1));
        end
        if (cmd.height_neg)
        begin
            res_next.stack_height = '1;
        end
        if (cmd.height_find)
        begin
            res_next.stack_height = found_reg ? SH_W'(old_reg) : '1;
        end
        if (cmd.scan_run && (mode_reg == SCAN_HIT) && p2_vld_reg && holds && !found_reg)
        begin
            res_next.result_id = p2_lid_reg;
        end
    end

    // Output register
    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg   <= '0;
            len_reg       <= '0;
            ptr_reg       <= '0;
            mode_reg      <= SCAN_FIND;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            next_id_reg   <= next_id_next;
            len_reg       <= len_next;
            ptr_reg       <= ptr_next;
            p1_vld_reg    <= p1_vld_next;
            p2_vld_reg    <= p2_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cmd.scan_start)
            begin
                mode_reg <= cmd.mode;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.h_load)
        begin
            h_reg <= h_fix;
        end
        if (find_hit)
        begin
            old_reg <= p1_idx_reg;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
        p1_idx_reg <= issue_idx;
        p2_lid_reg <= stk_rdata;
        res_reg    <= res_next;
    end

    // Shown layers are always a subset of the created ones
    a_len_le_ids: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= next_id_reg)
        else $error("stack longer than the number of created layers");

    a_next_id_max: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg <= CNT_W'(MAX_LAYERS))
        else $error("layer id counter past the table size");

    a_p2_hit: assert property (@(posedge clk) disable iff (!rst_n)
        p2_vld_reg |-> (item_reg.func == FUNC_HIT))
        else $error("attribute compare stage live outside a hit test");

    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_put |-> (len_reg < CNT_W'(MAX_LAYERS)))
        else $error("insert into a full stack");

endmodule

// ===== sv/layer_zorder_table_hit_test_core.sv =====
// ----------------------------------------------------------------------------
// layer_zorder_table_hit_test_core
// Layer table with a bottom-to-top z-order stack and a point hit test.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         one operation: func, layer id, coordinates, size,
//                       target height, skip id
//  m_axis    out        one result: status, result id, stack height
//
//  Create, unknown id and the unused code go straight to the result; set size
//  and moves add an attribute write. Get height and hit test walk the stack,
//  and set height walks it to find the layer, then to remove and insert it:
//  every stack walk goes through the single read port of the stack RAM, one
//  slot per cycle. Reset clears the id counter and the stack length; the RAMs
//  need no clearing. A new beat is taken while the previous result still
//  waits in the output register.
// ----------------------------------------------------------------------------
module layer_zorder_table_hit_test_core
    import lzt_pkg::*;
#(
    parameter int MAX_LAYERS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // func[2:0], tgt_id[8:3], coord_x[24:9], coord_y[40:25], size_w[56:41],
    // size_h[72:57], target_height[80:73], skip_id[86:81], zero pad[87]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[1:0], result_id[7:2], stack_height[14:8], zero pad[15]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int ITEM_W = $bits(lzt_item_t);
    localparam int RES_W  = $bits(lzt_result_t);

    lzt_item_t   item;
    lzt_cmd_t    cmd;
    lzt_stat_t   stat;
    lzt_result_t res;

    assign item    = s_tdata[ITEM_W-1:0];
    assign m_tdata = OUT_TDATA_W'({1'b0, res[RES_W-1:0]});

    // Sequencer
    lzt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Tables, stack walker and output register
    lzt_dp #(
        .MAX_LAYERS (MAX_LAYERS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (res)
    );

endmodule

// ===== tb/layer_zorder_table_hit_test_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_zorder_table_hit_test_checker
// Watches both stream channels of the layer table, keeps its own copy of the
// layer attributes and the z-order stack, predicts one result per accepted
// operation and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module layer_zorder_table_hit_test_checker
    import lzt_pkg::*;
#(
    parameter int MAX_LAYERS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending_count
);

    // Shadow copy of the layer table.
    int                    ids_given;
    logic signed [15:0]    pos_x [MAX_LAYERS];
    logic signed [15:0]    pos_y [MAX_LAYERS];
    logic [15:0]           win_w [MAX_LAYERS];
    logic [15:0]           win_h [MAX_LAYERS];
    bit                    win_on [MAX_LAYERS];
    int                    zstack [$];

    lzt_result_t           expected_results [$];

    function automatic bit id_known(int id);
        return id >= 1 && id <= ids_given;
    endfunction

    function automatic int height_of(int id);
        foreach (zstack[i])
            if (zstack[i] == id)
                return i;
        return -1;
    endfunction

    // Point containment without overflow, done on wide integers.
    function automatic bit covers(int k, longint px, longint py);
        longint x0;
        longint y0;
        x0 = pos_x[k];
        y0 = pos_y[k];
        return x0 <= px && px < x0 + longint'(win_w[k]) &&
               y0 <= py && py < y0 + longint'(win_h[k]);
    endfunction

    // Applies one operation to the shadow table and returns its result.
    function automatic lzt_result_t apply_operation(lzt_item_t op);
        lzt_result_t res;
        int id;
        int k;
        int old;
        int h;
        int th;
        res = '{stack_height: '0, result_id: '0, status: ST_OK};
        id = op.tgt_id;
        k = id - 1;
        th = op.target_height;
        if (op.func inside {FUNC_SIZE, FUNC_MOVE_ABS, FUNC_MOVE_REL, FUNC_SET_HEIGHT}
            && !id_known(id)) begin
            res.status = ST_UNKNOWN;
        end
        else begin
            case (op.func)
                FUNC_NEW:
                begin
                    if (ids_given >= MAX_LAYERS)
                        res.status = ST_FULL;
                    else begin
                        pos_x[ids_given] = '0;
                        pos_y[ids_given] = '0;
                        win_w[ids_given] = '0;
                        win_h[ids_given] = '0;
                        win_on[ids_given] = 1'b0;
                        ids_given++;
                        res.result_id = ID_W'(ids_given);
                    end
                end
                FUNC_SIZE:
                begin
                    win_w[k] = op.size_w;
                    win_h[k] = op.size_h;
                    win_on[k] = 1'b1;
                end
                FUNC_MOVE_ABS:
                begin
                    pos_x[k] = op.coord_x;
                    pos_y[k] = op.coord_y;
                end
                FUNC_MOVE_REL:
                begin
                    pos_x[k] = pos_x[k] + op.coord_x;
                    pos_y[k] = pos_y[k] + op.coord_y;
                end
                FUNC_SET_HEIGHT:
                begin
                    old = height_of(id);
                    if (th < 0) begin
                        if (old >= 0)
                            zstack.delete(old);
                    end
                    else begin
                        h = (th > zstack.size()) ? zstack.size() : th;
                        if (old >= 0) begin
                            if (h == zstack.size() && h > 0)
                                h--;
                            zstack.delete(old);
                        end
                        zstack.insert(h, id);
                    end
                end
                FUNC_HIT:
                begin
                    for (int i = zstack.size() - 1; i >= 0; i--) begin
                        if (zstack[i] != op.skip_id && win_on[zstack[i] - 1]
                            && covers(zstack[i] - 1, op.coord_x, op.coord_y)) begin
                            res.result_id = ID_W'(zstack[i]);
                            break;
                        end
                    end
                end
                FUNC_GET_HEIGHT:
                begin
                    if (!id_known(id))
                        res.status = ST_UNKNOWN;
                    res.stack_height = SH_W'(height_of(id));
                end
                default:
                begin
                end
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Prediction on input beats, comparison on output beats.
    always @(posedge clk or negedge rst_n)
    begin
        lzt_result_t got;
        lzt_result_t want;
        if (!rst_n) begin
            ids_given = 0;
            zstack.delete();
            expected_results.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(
                    apply_operation(lzt_item_t'(s_tdata[$bits(lzt_item_t)-1:0])));
            if (m_tvalid && m_tready) begin
                got = lzt_result_t'(m_tdata[14:0]);
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result beat", 1, 0);
                else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.result_id != want.result_id)
                        report_mismatch("result_id", got.result_id, want.result_id);
                    if (got.stack_height != want.stack_height)
                        report_mismatch("stack_height", got.stack_height,
                                        want.stack_height);
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== tb/layer_zorder_table_hit_test_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_zorder_table_hit_test_core_tb
// Drives directed and random layer operations into the layer table and
// gives the verdict from the failure count of the checker beside it.
// ----------------------------------------------------------------------------
module layer_zorder_table_hit_test_core_tb;
    import lzt_pkg::*;

    localparam int MAX_LAYERS  = 32;
    localparam int RANDOM_OPS  = 1630;
    localparam int STALL_LIMIT = 20000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     fail_count;
    int                     pending_count;
    int                     created;
    int                     quiet_cycles;
    bit                     rx_calm;
    bit                     rx_hold;
    bit                     tx_calm;

    layer_zorder_table_hit_test_core #(.MAX_LAYERS(MAX_LAYERS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    layer_zorder_table_hit_test_checker #(.MAX_LAYERS(MAX_LAYERS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog on cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, a calm stretch and one long hold-off.
    always @(negedge clk)
    begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= rx_calm || ($urandom_range(99) >= 19);
    end

    initial
    begin
        rx_calm = 1'b0;
        rx_hold = 1'b0;
        wait (created == 300);
        rx_calm = 1'b1;
        wait (created == 600);
        rx_calm = 1'b0;
        rx_hold = 1'b1;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
    end

    // Sends one beat, holding it until the block accepts it. Valid stays up
    // after the accept until the next beat or idle cycle replaces it.
    task automatic send_op(func_t f, int id, int cx, int cy, int w, int h, int th, int skip);
        lzt_item_t op;
        op.func = f;
        op.tgt_id = ID_W'(id);
        op.coord_x = IN_COORD_W'(cx);
        op.coord_y = IN_COORD_W'(cy);
        op.size_w = SIZE_W'(w);
        op.size_h = SIZE_W'(h);
        op.target_height = TH_W'(th);
        op.skip_id = ID_W'(skip);
        while (!tx_calm && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata <= {1'b0, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        created++;
    endtask

    // Random coordinate: mostly near the origin so hits happen, sometimes anything.
    function automatic int pick_coord();
        if ($urandom_range(3) == 0)
            return $urandom_range(65535);
        return int'($urandom_range(400)) - 200;
    endfunction

    function automatic int pick_id();
        return ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(34);
    endfunction

    initial
    begin
        int f;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        created = 0;
        quiet_cycles = 0;
        tx_calm = 1'b1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: unknown ids before any layer, then field extremes.
        send_op(FUNC_GET_HEIGHT, 0, 0, 0, 0, 0, 0, 0);
        send_op(FUNC_SIZE, 1, 0, 0, 5, 5, 0, 0);
        send_op(FUNC_NEW, 0, 0, 0, 0, 0, 0, 0);
        send_op(FUNC_NEW, 63, -1, -1, 65535, 65535, -1, 63);
        send_op(FUNC_MOVE_ABS, 1, 32767, -32768, 0, 0, 0, 0);
        send_op(FUNC_MOVE_REL, 1, 1, -1, 0, 0, 0, 0);
        send_op(FUNC_SET_HEIGHT, 1, 0, 0, 0, 0, 127, 0);
        send_op(FUNC_HIT, 5, 0, 0, 0, 0, 0, 0);
        send_op(FUNC_SIZE, 1, 0, 0, 65535, 65535, 0, 0);
        send_op(FUNC_HIT, 0, -32768, 32767, 0, 0, 0, 0);
        send_op(FUNC_MOVE_ABS, 2, -100, -100, 0, 0, 0, 0);
        send_op(FUNC_SET_HEIGHT, 2, 0, 0, 0, 0, 0, 0);
        send_op(FUNC_HIT, 0, -100, -100, 0, 0, 0, 0);
        send_op(FUNC_SIZE, 2, 0, 0, 10, 10, 0, 0);
        send_op(FUNC_HIT, 0, -100, -100, 0, 0, 0, 1);
        send_op(FUNC_HIT, 0, -100, -100, 0, 0, 0, 2);
        send_op(FUNC_GET_HEIGHT, 2, 0, 0, 0, 0, 0, 0);
        send_op(FUNC_SET_HEIGHT, 2, 0, 0, 0, 0, -128, 0);
        send_op(FUNC_GET_HEIGHT, 2, 0, 0, 0, 0, 0, 0);
        send_op(func_t'(3'd7), 1, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 32; i++)
            send_op(FUNC_NEW, 0, 0, 0, 0, 0, 0, 0);

        // Random operations; a stretch in the middle is sent with no idle gaps.
        tx_calm = 1'b0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n > 150 && n < 400)
                tx_calm = 1'b1;
            else
                tx_calm = 1'b0;
            f = $urandom_range(99);
            if (f < 5)
                send_op(func_t'(3'd7), pick_id(), 0, 0, 0, 0, 0, 0);
            else if (f < 20)
                send_op(FUNC_SIZE, pick_id(), 0, 0, $urandom_range(300),
                        ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(300),
                        0, 0);
            else if (f < 30)
                send_op(FUNC_MOVE_ABS, pick_id(), pick_coord(), pick_coord(), 0, 0, 0, 0);
            else if (f < 38)
                send_op(FUNC_MOVE_REL, pick_id(), pick_coord(), pick_coord(), 0, 0, 0, 0);
            else if (f < 60)
                send_op(FUNC_SET_HEIGHT, pick_id(), 0, 0, 0, 0,
                        ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(40),
                        0);
            else if (f < 85)
                send_op(FUNC_HIT, $urandom_range(63), pick_coord(), pick_coord(), 0, 0, 0,
                        ($urandom_range(2) == 0) ? 0 : $urandom_range(63));
            else
                send_op(FUNC_GET_HEIGHT, pick_id(), 0, 0, 0, 0, 0, 0);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the block's own latency before the verdict.
        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
